// ===== rtl/gtpf_pkg.sv =====
`timescale 1ns / 1ps

package gtpf_pkg;

   // action codes carried by a request
   typedef enum logic [2:0] {
      ACT_LOAD    = 3'd0,
      ACT_DRAW    = 3'd1,
      ACT_RESTART = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_READ    = 3'd4
   } action_type;

   // text line selects
   localparam logic [1:0] LINE_UPPER = 2'd1;
   localparam logic [1:0] LINE_LOWER = 2'd2;

   // response status codes
   localparam logic [1:0] RSP_OK       = 2'd0;
   localparam logic [1:0] RSP_NO_GLYPH = 2'd1;
   localparam logic [1:0] RSP_CLIPPED  = 2'd2;

   // first character code held in the font
   localparam logic [7:0] FIRST_CODE = 8'd32;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  text_line;
      logic [7:0]  char_code;
      logic [11:0] font_address;
      logic [7:0]  font_value;
      logic [8:0]  read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_WIDTH,
      S_COLS,
      S_DRAIN,
      S_CLEAR,
      S_FRAME_RD,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // request channel ready
      logic clr_step;    // write one zero byte of the clearing sweep
      logic base_calc;   // register the glyph base address
      logic width_rd;    // read the glyph width byte
      logic col_issue;   // read one column byte, write it in the next cycle
      logic cursor_upd;  // advance the cursor of the drawn line
      logic frame_rd;    // read one frame byte
      logic rsp_load;    // load the response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       req_valid;
      logic [2:0] req_action;
      logic       line_ok;
      logic       glyph_ok;
      logic       clr_last;
      logic       col_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== rtl/gtpf_if.sv =====
`timescale 1ns / 1ps

interface gtpf_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/gtpf_ram.sv =====
`timescale 1ns / 1ps

module gtpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gtpf_ctrl.sv =====
`timescale 1ns / 1ps

module gtpf_ctrl
   import gtpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.req_valid) begin
               unique case (stat.req_action)
                  ACT_DRAW:  state_in = S_CHECK;
                  ACT_CLEAR: state_in = S_CLEAR;
                  ACT_READ:  state_in = S_FRAME_RD;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_CHECK: begin
            cmd.base_calc = 1'b1;
            state_in = (stat.line_ok && stat.glyph_ok) ? S_WIDTH : S_FINISH;
         end
         S_WIDTH: begin
            cmd.width_rd = 1'b1;
            state_in = S_COLS;
         end
         S_COLS: begin
            cmd.col_issue = 1'b1;
            if (stat.col_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last column byte is written here
            cmd.cursor_upd = 1'b1;
            state_in = S_FINISH;
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_FINISH;
            end
         end
         S_FRAME_RD: begin
            cmd.frame_rd = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

endmodule

// ===== rtl/gtpf_dpath.sv =====
`timescale 1ns / 1ps

module gtpf_dpath
   import gtpf_pkg::*;
#(
   parameter int COLUMNS         = 128,
   parameter int GLYPH_WIDTH_MAX = 12,
   parameter int GLYPH_STRIDE    = 25,
   parameter int GLYPH_COUNT     = 95,
   parameter int BUFFER_BYTES    = 512
) (
   input  logic     clock,
   input  logic     reset,
   gtpf_if.sink     req_if,
   gtpf_if.source   rsp_if,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int FONT_BYTES = GLYPH_COUNT * GLYPH_STRIDE;
   localparam int FONT_AW    = $clog2(FONT_BYTES);
   localparam int FOFF_W     = $clog2(FONT_BYTES + 2 * GLYPH_WIDTH_MAX + 1);
   localparam int FRAME_AW   = $clog2(BUFFER_BYTES);
   localparam int PAGE_W     = $clog2(4 * COLUMNS);
   localparam int CUR_W      = $clog2(COLUMNS + 1);
   localparam int COL_W      = CUR_W + 1;
   localparam int K_W        = $clog2(2 * GLYPH_WIDTH_MAX);
   localparam int SUM_W      = ((CUR_W > 8) ? CUR_W : 8) + 1;

   req_type req;
   logic    accept;

   assign req          = req_if.payload;
   assign req_if.ready = cmd.take;
   assign accept       = req_if.valid && req_if.ready;

   // captured request
   logic [2:0] act_ff;
   logic [1:0] line_ff;
   logic [7:0] code_ff;
   logic [8:0] raddr_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req.action;
         line_ff  <= req.text_line;
         code_ff  <= req.char_code;
         raddr_ff <= req.read_address;
      end
   end

   // glyph decode
   logic [7:0] glyph_idx;
   logic       glyph_ok;
   logic       line_ok;

   assign glyph_idx = code_ff - FIRST_CODE;
   assign glyph_ok  = (code_ff >= FIRST_CODE) && (32'(glyph_idx) < 32'(GLYPH_COUNT));
   assign line_ok   = (line_ff == LINE_UPPER) || (line_ff == LINE_LOWER);

   // glyph base address
   logic [FOFF_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (cmd.base_calc) begin
         base_ff <= FOFF_W'(32'(glyph_idx) * 32'(GLYPH_STRIDE));
      end
   end

   // column byte counter and the write stage behind the font read
   logic [K_W-1:0]    k_ff, k_in;
   logic              wr_pend_ff;
   logic [K_W-1:0]    wr_k_ff;
   logic              wr_oob_ff;
   logic              col_last;
   logic [FOFF_W-1:0] font_caddr;
   logic              font_oob;

   assign col_last   = (32'(k_ff) == 32'(2 * GLYPH_WIDTH_MAX - 1));
   assign font_caddr = base_ff + FOFF_W'(k_ff) + FOFF_W'(1);
   assign font_oob   = (32'(font_caddr) >= 32'(FONT_BYTES));

   always_comb begin
      k_in = k_ff;
      if (cmd.width_rd) begin
         k_in = '0;
      end else if (cmd.col_issue) begin
         k_in = k_ff + K_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff       <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         k_ff       <= k_in;
         wr_pend_ff <= cmd.col_issue;
      end
   end

   always_ff @(posedge clock) begin
      wr_k_ff   <= k_ff;
      wr_oob_ff <= font_oob;
   end

   // font memory
   logic              font_we;
   logic [FONT_AW-1:0] font_waddr;
   logic              font_re;
   logic [FONT_AW-1:0] font_raddr;
   logic [7:0]         font_rdata;

   assign font_we    = accept && (req.action == ACT_LOAD)
                       && (32'(req.font_address) < 32'(FONT_BYTES));
   assign font_waddr = FONT_AW'(32'(req.font_address));
   assign font_re    = cmd.width_rd || cmd.col_issue;
   assign font_raddr = cmd.col_issue ? FONT_AW'(font_caddr) : FONT_AW'(base_ff);

   gtpf_ram #(
      .WIDTH (8),
      .DEPTH (FONT_BYTES)
   ) u_font_ram (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (font_waddr),
      .wr_data (req.font_value),
      .rd_en   (font_re),
      .rd_addr (font_raddr),
      .rd_data (font_rdata)
   );

   // glyph width byte arrives on the first column cycle
   logic [7:0] wid_ff;

   always_ff @(posedge clock) begin
      if (cmd.col_issue && (k_ff == '0)) begin
         wid_ff <= font_rdata;
      end
   end

   // cursors
   logic [CUR_W-1:0] cur_upper_ff, cur_upper_in;
   logic [CUR_W-1:0] cur_lower_ff, cur_lower_in;
   logic [CUR_W-1:0] cur_sel;
   logic [SUM_W-1:0] cur_sum;
   logic [CUR_W-1:0] cur_next;

   assign cur_sel  = (line_ff == LINE_UPPER) ? cur_upper_ff : cur_lower_ff;
   assign cur_sum  = SUM_W'(cur_sel) + SUM_W'(wid_ff);
   assign cur_next = (32'(cur_sum) > 32'(COLUMNS)) ? CUR_W'(COLUMNS) : CUR_W'(cur_sum);

   always_comb begin
      cur_upper_in = cur_upper_ff;
      cur_lower_in = cur_lower_ff;
      if (accept && (req.action == ACT_RESTART)) begin
         cur_upper_in = '0;
         cur_lower_in = '0;
      end else if (cmd.cursor_upd) begin
         if (line_ff == LINE_UPPER) begin
            cur_upper_in = cur_next;
         end else begin
            cur_lower_in = cur_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_upper_ff <= '0;
         cur_lower_ff <= '0;
      end else begin
         cur_upper_ff <= cur_upper_in;
         cur_lower_ff <= cur_lower_in;
      end
   end

   // column write address: page base, lower page of the pair, cursor plus column
   logic [COL_W-1:0]  col;
   logic              in_cols;
   logic [PAGE_W-1:0] page_addr;
   logic              page_ok;
   logic              col_we;

   assign col       = COL_W'(cur_sel) + COL_W'(wr_k_ff >> 1);
   assign in_cols   = (32'(col) < 32'(COLUMNS));
   assign page_addr = ((line_ff == LINE_LOWER) ? PAGE_W'(2 * COLUMNS) : '0)
                      + (wr_k_ff[0] ? PAGE_W'(COLUMNS) : '0)
                      + PAGE_W'(col);
   assign page_ok   = (32'(page_addr) < 32'(BUFFER_BYTES));
   assign col_we    = wr_pend_ff && in_cols && page_ok;

   // clipping flag
   logic clipped_ff, clipped_in;

   always_comb begin
      clipped_in = clipped_ff;
      if (accept) begin
         clipped_in = 1'b0;
      end else if (wr_pend_ff && !in_cols) begin
         clipped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clipped_ff <= 1'b0;
      end else begin
         clipped_ff <= clipped_in;
      end
   end

   // clearing sweep counter
   logic [FRAME_AW-1:0] clr_ff, clr_in;
   logic                clr_last;

   assign clr_last = (32'(clr_ff) == 32'(BUFFER_BYTES - 1));

   always_comb begin
      clr_in = clr_ff;
      if (cmd.clr_step) begin
         clr_in = clr_last ? '0 : clr_ff + FRAME_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // frame memory
   logic                frame_we;
   logic [FRAME_AW-1:0] frame_waddr;
   logic [7:0]          frame_wdata;
   logic [7:0]          frame_rdata;
   logic                rd_ok;

   assign frame_we    = cmd.clr_step || col_we;
   assign frame_waddr = cmd.clr_step ? clr_ff : FRAME_AW'(page_addr);
   assign frame_wdata = (cmd.clr_step || wr_oob_ff) ? 8'd0 : font_rdata;
   assign rd_ok       = (32'(raddr_ff) < 32'(BUFFER_BYTES));

   gtpf_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (cmd.frame_rd),
      .rd_addr (FRAME_AW'(raddr_ff)),
      .rd_data (frame_rdata)
   );

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_in.read_data = ((act_ff == ACT_READ) && rd_ok) ? frame_rdata : 8'd0;
      rsp_in.status    = RSP_OK;
      if ((act_ff == ACT_DRAW) && line_ok) begin
         if (!glyph_ok) begin
            rsp_in.status = RSP_NO_GLYPH;
         end else if (clipped_ff) begin
            rsp_in.status = RSP_CLIPPED;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // status to controller
   assign stat.req_valid  = req_if.valid;
   assign stat.req_action = req.action;
   assign stat.line_ok    = line_ok;
   assign stat.glyph_ok   = glyph_ok;
   assign stat.clr_last   = clr_last;
   assign stat.col_last   = col_last;
   assign stat.out_free   = out_free;

   // a new response never overwrites one that has not been taken
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response overwritten before transfer");

   // the clearing sweep and a column write never share the write port
   a_wr_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && wr_pend_ff))
      else $error("frame write port conflict");

   // cursors stay within the page
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_upper_ff) <= 32'(COLUMNS)) && (32'(cur_lower_ff) <= 32'(COLUMNS)))
      else $error("cursor beyond page width");

   // no request is taken while a glyph copy is still writing
   a_no_take_mid_copy: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> !accept)
      else $error("request taken during glyph copy");

endmodule

// ===== rtl/glyph_to_page_framebuffer.sv =====
`timescale 1ns / 1ps
// Draw: line and code checked, width byte read, 2*GLYPH_WIDTH_MAX column bytes
//   copied at one glyph byte per cycle through the frame memory's single write port.
// A bad line or code skips the copy; Clear sweeps every byte of the frame memory.
// One item at a time; req ready returns the cycle after the response register loads.
// Synchronous active-high reset; afterwards a clearing pass zeroes the frame memory
//   with req ready low. Font memory is not cleared.

module glyph_to_page_framebuffer
   import gtpf_pkg::*;
#(
   parameter int COLUMNS         = 128,
   parameter int GLYPH_WIDTH_MAX = 12,
   parameter int GLYPH_STRIDE    = 25,
   parameter int GLYPH_COUNT     = 95,
   parameter int BUFFER_BYTES    = 512
) (
   input  logic   clock,
   input  logic   reset,
   gtpf_if.sink   req_if,
   gtpf_if.source rsp_if
);

   cmd_type  cmd;
   stat_type stat;

   gtpf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   gtpf_dpath #(
      .COLUMNS         (COLUMNS),
      .GLYPH_WIDTH_MAX (GLYPH_WIDTH_MAX),
      .GLYPH_STRIDE    (GLYPH_STRIDE),
      .GLYPH_COUNT     (GLYPH_COUNT),
      .BUFFER_BYTES    (BUFFER_BYTES)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .stat   (stat)
   );

endmodule
